// File: design/rsx_pkg.sv
package rsx_pkg;

	localparam int unsigned XLEN          = 64;
	localparam int unsigned REG_COUNT     = 32;
	localparam int unsigned REG_IDX_BITS  = 5;
	localparam int unsigned TARGET_BITS   = 16;
	localparam int unsigned MEM_DEPTH_DEF = 1024;
	localparam int unsigned PC_BITS_DEF   = 16;

	// Return address register used by call.
	localparam logic [REG_IDX_BITS-1:0] RA_REG = 5'd1;

	typedef enum logic [4:0] {
		OP_ADDI  = 5'd0,
		OP_SD    = 5'd1,
		OP_SW    = 5'd2,
		OP_LI    = 5'd3,
		OP_J     = 5'd4,
		OP_LW    = 5'd5,
		OP_SEXTW = 5'd6,
		OP_ADDIW = 5'd7,
		OP_BGE   = 5'd8,
		OP_BLE   = 5'd9,
		OP_MULW  = 5'd10,
		OP_ADDW  = 5'd11,
		OP_MV    = 5'd12,
		OP_LD    = 5'd13,
		OP_CALL  = 5'd14,
		OP_JR    = 5'd15
	} op_t;

	// Effects of one instruction, produced by the execute logic.
	typedef struct packed {
		logic                    wreg;
		logic [REG_IDX_BITS-1:0] widx;
		logic [XLEN-1:0]         wval;
		logic                    wmem;
		logic                    mem_acc;
		logic                    is_load;
		logic                    load_sext;
		logic [XLEN-1:0]         addr;
		logic [XLEN-1:0]         mdata;
		logic                    halt_set;
	} exec_t;

	function automatic logic [XLEN-1:0] sext32(input logic [31:0] v);
		return {{32{v[31]}}, v};
	endfunction

endpackage

// File: design/riscv_subset_executor.sv
// Executes one decoded instruction of the RV64 subset per transfer and
// returns one result per instruction, in order. The block is a three-step
// pipeline and accepts a new instruction every cycle, dependent ones
// included, unless a result not taken by out_ready stalls it: the register
// file is read at acceptance, the execute stage applies forwarding and
// reads or writes the data memory, and the result stage offers the result.
// The register file is written when a result transfers. After reset the
// data memory is cleared one word per cycle, and no instruction is accepted
// until every word is cleared. MEM_DEPTH must be a power of two; addresses
// wrap at that depth. An unknown operation halts the block until reset.
module riscv_subset_executor #(
	parameter int unsigned MEM_DEPTH = rsx_pkg::MEM_DEPTH_DEF,
	parameter int unsigned PC_BITS   = rsx_pkg::PC_BITS_DEF,
	localparam int unsigned ADDR_BITS = $clog2(MEM_DEPTH)
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic [4:0]                              kind,
	input  logic [rsx_pkg::REG_IDX_BITS-1:0]        dest_index,
	input  logic [rsx_pkg::REG_IDX_BITS-1:0]        src_a_index,
	input  logic [rsx_pkg::REG_IDX_BITS-1:0]        src_b_index,
	input  logic signed [rsx_pkg::XLEN-1:0]         immediate,
	input  logic [rsx_pkg::TARGET_BITS-1:0]         jump_target,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [PC_BITS-1:0]                      next_pc,
	output logic                                    reg_written,
	output logic [rsx_pkg::REG_IDX_BITS-1:0]        written_reg,
	output logic signed [rsx_pkg::XLEN-1:0]         written_value,
	output logic                                    mem_written,
	output logic [ADDR_BITS-1:0]                    mem_address,
	output logic signed [rsx_pkg::XLEN-1:0]         mem_data,
	output logic                                    halted
);

	localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(MEM_DEPTH - 1);

	// Clearing pass state.
	logic                  clearing_q;
	logic [ADDR_BITS-1:0]  clr_addr_q;

	// Architectural state outside the memories.
	logic [PC_BITS-1:0]    pc_q;
	logic                  halt_q;

	// Most recent register file write, for reads issued on the same edge.
	logic                             lw_en_q;
	logic [rsx_pkg::REG_IDX_BITS-1:0] lw_idx_q;
	logic [rsx_pkg::XLEN-1:0]         lw_val_q;

	// Execute stage.
	logic                             valid_s1;
	logic                             fresh_s1;
	logic [4:0]                       kind_s1;
	logic [rsx_pkg::REG_IDX_BITS-1:0] rd_s1;
	logic [rsx_pkg::REG_IDX_BITS-1:0] ra_s1;
	logic [rsx_pkg::REG_IDX_BITS-1:0] rb_s1;
	logic [rsx_pkg::XLEN-1:0]         imm_s1;
	logic [rsx_pkg::TARGET_BITS-1:0]  tgt_s1;
	logic [rsx_pkg::XLEN-1:0]         a_hold_q;
	logic [rsx_pkg::XLEN-1:0]         b_hold_q;

	// Result stage.
	logic                             valid_s2;
	logic                             wreg_s2;
	logic [rsx_pkg::REG_IDX_BITS-1:0] widx_s2;
	logic [rsx_pkg::XLEN-1:0]         wval_s2;
	logic                             is_load_s2;
	logic                             load_sext_s2;
	logic                             wmem_s2;
	logic                             mem_acc_s2;
	logic [ADDR_BITS-1:0]             maddr_s2;
	logic [rsx_pkg::XLEN-1:0]         mdata_s2;
	logic [PC_BITS-1:0]               next_pc_s2;
	logic                             halted_s2;

	logic                             in_xfer;
	logic                             out_xfer;
	logic                             adv1;
	logic                             rf_we;
	logic [rsx_pkg::XLEN-1:0]         rf_a;
	logic [rsx_pkg::XLEN-1:0]         rf_b;
	logic [rsx_pkg::XLEN-1:0]         a_eff;
	logic [rsx_pkg::XLEN-1:0]         b_eff;
	logic [rsx_pkg::XLEN-1:0]         s2_wdata;
	logic [rsx_pkg::XLEN-1:0]         dmem_rdata;
	rsx_pkg::exec_t                   ex;
	logic [PC_BITS-1:0]               ex_next_pc;
	logic                             dmem_we;
	logic [ADDR_BITS-1:0]             dmem_waddr;
	logic [rsx_pkg::XLEN-1:0]         dmem_wdata;

	assign adv1     = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !clearing_q && (!valid_s1 || adv1);
	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = valid_s2 && out_ready;
	assign rf_we    = out_xfer && wreg_s2;

	assign s2_wdata = is_load_s2 ?
		(load_sext_s2 ? rsx_pkg::sext32(dmem_rdata[31:0]) : dmem_rdata) : wval_s2;

	rsx_regfile u_regfile (
		.clk(clk), .arst_n(arst_n),
		.rd_en(in_xfer), .ra(src_a_index), .rb(src_b_index),
		.we(rf_we), .widx(widx_s2), .wdata(s2_wdata),
		.rdata_a(rf_a), .rdata_b(rf_b)
	);

	// The instruction in the result stage is the newest older write; on its
	// first cycle the operand also sees a write made at the read edge, and
	// afterwards the held operand already carries everything older.
	function automatic logic [rsx_pkg::XLEN-1:0] resolve(
		input logic [rsx_pkg::REG_IDX_BITS-1:0] idx,
		input logic [rsx_pkg::XLEN-1:0]         ram,
		input logic [rsx_pkg::XLEN-1:0]         hold
	);
		logic [rsx_pkg::XLEN-1:0] v;
		if (valid_s2 && wreg_s2 && widx_s2 == idx) begin
			v = s2_wdata;
		end else if (!fresh_s1) begin
			v = hold;
		end else if (lw_en_q && lw_idx_q == idx) begin
			v = lw_val_q;
		end else begin
			v = ram;
		end
		return v;
	endfunction

	// The function reads stage state directly, so these must re-evaluate on it.
	always_comb begin
		a_eff = resolve(ra_s1, rf_a, a_hold_q);
		b_eff = resolve(rb_s1, rf_b, b_hold_q);
	end

	rsx_alu #(.PC_BITS(PC_BITS)) u_alu (
		.kind(kind_s1), .rd(rd_s1), .a(a_eff), .b(b_eff), .imm(imm_s1),
		.target(tgt_s1), .pc(pc_q), .halted(halt_q),
		.res(ex), .next_pc(ex_next_pc)
	);

	always_comb begin
		if (clearing_q) begin
			dmem_we    = 1'b1;
			dmem_waddr = clr_addr_q;
			dmem_wdata = '0;
		end else begin
			dmem_we    = adv1 && ex.wmem;
			dmem_waddr = ex.addr[ADDR_BITS-1:0];
			dmem_wdata = ex.mdata;
		end
	end

	rsx_ram #(.WIDTH(rsx_pkg::XLEN), .DEPTH(MEM_DEPTH)) u_dmem (
		.clk(clk), .we(dmem_we), .waddr(dmem_waddr), .wdata(dmem_wdata),
		.re(adv1 && ex.is_load), .raddr(ex.addr[ADDR_BITS-1:0]), .rdata(dmem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
			pc_q       <= '0;
			halt_q     <= 1'b0;
			lw_en_q    <= 1'b0;
			valid_s1   <= 1'b0;
			fresh_s1   <= 1'b0;
			valid_s2   <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + ADDR_BITS'(1);
				if (clr_addr_q == LAST_ADDR) begin
					clearing_q <= 1'b0;
				end
			end
			if (rf_we) begin
				lw_en_q <= 1'b1;
			end
			if (in_xfer) begin
				valid_s1 <= 1'b1;
				fresh_s1 <= 1'b1;
			end else begin
				fresh_s1 <= 1'b0;
				if (adv1) begin
					valid_s1 <= 1'b0;
				end
			end
			if (adv1) begin
				valid_s2 <= 1'b1;
				pc_q     <= ex_next_pc;
				if (ex.halt_set) begin
					halt_q <= 1'b1;
				end
			end else if (out_xfer) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		a_hold_q <= a_eff;
		b_hold_q <= b_eff;
		if (rf_we) begin
			lw_idx_q <= widx_s2;
			lw_val_q <= s2_wdata;
		end
		if (in_xfer) begin
			kind_s1 <= kind;
			rd_s1   <= dest_index;
			ra_s1   <= src_a_index;
			rb_s1   <= src_b_index;
			imm_s1  <= immediate;
			tgt_s1  <= jump_target;
		end
		if (adv1) begin
			wreg_s2      <= ex.wreg;
			widx_s2      <= ex.widx;
			wval_s2      <= ex.wval;
			is_load_s2   <= ex.is_load;
			load_sext_s2 <= ex.load_sext;
			wmem_s2      <= ex.wmem;
			mem_acc_s2   <= ex.mem_acc;
			maddr_s2     <= ex.addr[ADDR_BITS-1:0];
			mdata_s2     <= ex.mdata;
			next_pc_s2   <= ex_next_pc;
			halted_s2    <= halt_q || ex.halt_set;
		end
	end

	assign out_valid     = valid_s2;
	assign next_pc       = next_pc_s2;
	assign reg_written   = wreg_s2;
	assign written_reg   = widx_s2;
	assign written_value = wreg_s2 ? s2_wdata : '0;
	assign mem_written   = wmem_s2;
	assign mem_address   = mem_acc_s2 ? maddr_s2 : '0;
	assign mem_data      = wmem_s2 ? mdata_s2 : '0;
	assign halted        = halted_s2;

	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !in_ready)
		else $error("instruction accepted during memory clear");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> halt_q)
		else $error("halt flag dropped without reset");

	a_no_store_when_halted: assert property (@(posedge clk) disable iff (!arst_n)
		(adv1 && ex.wmem) |-> !halt_q)
		else $error("store executed while halted");

	a_no_x0_write: assert property (@(posedge clk) disable iff (!arst_n)
		rf_we |-> (widx_s2 != '0))
		else $error("register x0 written");

endmodule

// File: design/rsx_ram.sv
module rsx_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 32,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: design/rsx_regfile.sv
module rsx_regfile (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             rd_en,
	input  logic [rsx_pkg::REG_IDX_BITS-1:0] ra,
	input  logic [rsx_pkg::REG_IDX_BITS-1:0] rb,
	input  logic                             we,
	input  logic [rsx_pkg::REG_IDX_BITS-1:0] widx,
	input  logic [rsx_pkg::XLEN-1:0]         wdata,
	output logic [rsx_pkg::XLEN-1:0]         rdata_a,
	output logic [rsx_pkg::XLEN-1:0]         rdata_b
);

	logic [rsx_pkg::REG_COUNT-1:0]    valid_q;
	logic [rsx_pkg::REG_IDX_BITS-1:0] ra_q;
	logic [rsx_pkg::REG_IDX_BITS-1:0] rb_q;
	logic [rsx_pkg::XLEN-1:0]         ram_a;
	logic [rsx_pkg::XLEN-1:0]         ram_b;

	// Two copies written together give two read ports.
	rsx_ram #(.WIDTH(rsx_pkg::XLEN), .DEPTH(rsx_pkg::REG_COUNT)) u_bank_a (
		.clk(clk), .we(we), .waddr(widx), .wdata(wdata),
		.re(rd_en), .raddr(ra), .rdata(ram_a)
	);

	rsx_ram #(.WIDTH(rsx_pkg::XLEN), .DEPTH(rsx_pkg::REG_COUNT)) u_bank_b (
		.clk(clk), .we(we), .waddr(widx), .wdata(wdata),
		.re(rd_en), .raddr(rb), .rdata(ram_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ra_q    <= '0;
			rb_q    <= '0;
		end else begin
			if (we) begin
				valid_q[widx] <= 1'b1;
			end
			if (rd_en) begin
				ra_q <= ra;
				rb_q <= rb;
			end
		end
	end

	// An entry never written reads as zero; x0 is never written.
	assign rdata_a = valid_q[ra_q] ? ram_a : '0;
	assign rdata_b = valid_q[rb_q] ? ram_b : '0;

endmodule

// File: design/rsx_alu.sv
module rsx_alu #(
	parameter int unsigned PC_BITS = rsx_pkg::PC_BITS_DEF
) (
	input  logic [4:0]                       kind,
	input  logic [rsx_pkg::REG_IDX_BITS-1:0] rd,
	input  logic [rsx_pkg::XLEN-1:0]         a,
	input  logic [rsx_pkg::XLEN-1:0]         b,
	input  logic [rsx_pkg::XLEN-1:0]         imm,
	input  logic [rsx_pkg::TARGET_BITS-1:0]  target,
	input  logic [PC_BITS-1:0]               pc,
	input  logic                             halted,
	output rsx_pkg::exec_t                   res,
	output logic [PC_BITS-1:0]               next_pc
);

	logic [31:0]             target32;
	logic [PC_BITS-1:0]      pc_target;
	logic [PC_BITS-1:0]      pc_inc;
	logic [31:0]             prod;
	logic [31:0]             sum_w;
	logic [31:0]             sum_iw;
	logic [rsx_pkg::XLEN-1:0] sum_ai;
	logic                    a_ge_b;
	logic                    a_le_b;
	rsx_pkg::exec_t          r;

	assign target32  = {{(32-rsx_pkg::TARGET_BITS){1'b0}}, target};
	assign pc_target = target32[PC_BITS-1:0];
	assign pc_inc    = pc + PC_BITS'(1);
	assign prod      = a[31:0] * b[31:0];
	assign sum_w     = a[31:0] + b[31:0];
	assign sum_iw    = a[31:0] + imm[31:0];
	assign sum_ai    = a + imm;
	assign a_ge_b    = $signed(a) >= $signed(b);
	assign a_le_b    = $signed(a) <= $signed(b);

	always_comb begin
		r         = '0;
		r.widx    = rd;
		r.addr    = sum_ai;
		next_pc   = pc_inc;
		if (halted) begin
			next_pc = pc;
		end else begin
			unique case (rsx_pkg::op_t'(kind))
				rsx_pkg::OP_ADDI: begin
					r.wreg = 1'b1;
					r.wval = sum_ai;
				end
				rsx_pkg::OP_SD, rsx_pkg::OP_SW: begin
					r.wmem    = 1'b1;
					r.mem_acc = 1'b1;
					r.mdata   = b;
				end
				rsx_pkg::OP_LI: begin
					r.wreg = 1'b1;
					r.wval = imm;
				end
				rsx_pkg::OP_J: next_pc = pc_target;
				rsx_pkg::OP_LW: begin
					r.wreg      = 1'b1;
					r.mem_acc   = 1'b1;
					r.is_load   = 1'b1;
					r.load_sext = 1'b1;
				end
				rsx_pkg::OP_SEXTW: begin
					r.wreg = 1'b1;
					r.wval = rsx_pkg::sext32(a[31:0]);
				end
				rsx_pkg::OP_ADDIW: begin
					r.wreg = 1'b1;
					r.wval = rsx_pkg::sext32(sum_iw);
				end
				rsx_pkg::OP_BGE: if (a_ge_b) next_pc = pc_target;
				rsx_pkg::OP_BLE: if (a_le_b) next_pc = pc_target;
				rsx_pkg::OP_MULW: begin
					r.wreg = 1'b1;
					r.wval = rsx_pkg::sext32(prod);
				end
				rsx_pkg::OP_ADDW: begin
					r.wreg = 1'b1;
					r.wval = rsx_pkg::sext32(sum_w);
				end
				rsx_pkg::OP_MV: begin
					r.wreg = 1'b1;
					r.wval = a;
				end
				rsx_pkg::OP_LD: begin
					r.wreg    = 1'b1;
					r.mem_acc = 1'b1;
					r.is_load = 1'b1;
				end
				rsx_pkg::OP_CALL: begin
					r.wreg  = 1'b1;
					r.widx  = rsx_pkg::RA_REG;
					r.wval  = {{(rsx_pkg::XLEN-PC_BITS){1'b0}}, pc};
					next_pc = pc_target;
				end
				rsx_pkg::OP_JR: next_pc = a[PC_BITS-1:0] + PC_BITS'(1);
				default: begin
					r.halt_set = 1'b1;
					next_pc    = pc;
				end
			endcase
		end
		// A write to x0 is dropped and reported as no write.
		if (r.widx == '0) begin
			r.wreg = 1'b0;
		end
		if (!r.wreg) begin
			r.widx = '0;
			r.wval = '0;
		end
		res = r;
	end

endmodule
